@@ hw/rtl/pft_pkg.sv @@
// Shared types and constants for the page frame table with timestamp LRU.
package pft_pkg;

  // Fixed field widths and upper bounds of the parameter ranges
  localparam int FRAME_W_MAX = 8;   // frame index width at the largest frame count
  localparam int OFF_W_MAX   = 4;   // slot offset width at the largest page size
  localparam int OWNER_W_MAX = 16;  // widest owner tag
  localparam int PAGE_W      = 10;
  localparam int LINE_W      = 12;
  localparam int STAMP_W     = 32;
  localparam int SLOT_W      = 6;
  localparam int FOUT_W      = 4;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_VICTIM = 3'd3,
    CMD_FREE   = 3'd4,
    CMD_TOUCH  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FRAME  = 2'd1,
    ST_BAD_OFFSET = 2'd2,
    ST_MISS       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_DONE
  } state_t;

  // Command token handed from cell to cell, with the running result
  typedef struct packed {
    logic                   vld;
    logic [2:0]             cmd;
    logic                   wr;          // load or touch that updates its frame
    logic [FRAME_W_MAX-1:0] frame;
    logic [OWNER_W_MAX-1:0] owner;
    logic [PAGE_W-1:0]      page;
    logic [LINE_W-1:0]      lpage;       // lookup page
    logic [OFF_W_MAX-1:0]   offs;        // load offset or lookup offset
    logic [STAMP_W-1:0]     stamp;
    logic                   found;
    logic [FRAME_W_MAX-1:0] idx;
    logic [STAMP_W-1:0]     best_stamp;
    logic [SLOT_W-1:0]      slot;
    status_t                st;
  } pft_tok_t;

endpackage

@@ hw/rtl/pft_cell.sv @@
// One frame of the table: frame state plus one stage of the command chain.
module pft_cell import pft_pkg::*; #(
  parameter int IDX            = 0,
  parameter int NUM_FRAMES     = 16,
  parameter int SLOTS_PER_PAGE = 4,
  parameter int OWNER_BITS     = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  pft_tok_t tok_in,
  output pft_tok_t tok_out
);

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int OFW = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam logic [FW-1:0] MY_IDX = FW'(IDX);

  // Frame state
  logic                      valid;
  logic [OWNER_BITS-1:0]     tag;
  logic [PAGE_W-1:0]         page;
  logic                      stamped;
  logic [STAMP_W-1:0]        stamp;
  logic [SLOTS_PER_PAGE-1:0] loaded;

  logic     hit_me;
  logic     own_match;
  logic     page_match;
  logic     slot_sel;
  pft_tok_t tok_next;

  assign hit_me     = tok_in.vld && tok_in.wr && (tok_in.frame[FW-1:0] == MY_IDX);
  assign own_match  = valid && (tag == tok_in.owner[OWNER_BITS-1:0]);
  assign page_match = ({{(LINE_W-PAGE_W){1'b0}}, page} == tok_in.lpage);
  assign slot_sel   = loaded[tok_in.offs[OFW-1:0]];

  // Update the running result as the token passes
  always_comb begin
    tok_next = tok_in;
    case (tok_in.cmd)
      CMD_LOOKUP: begin
        if (!tok_in.found && own_match && page_match && slot_sel) begin
          tok_next.found = 1'b1;
          tok_next.idx   = FRAME_W_MAX'(IDX);
          tok_next.slot  = SLOT_W'(IDX * SLOTS_PER_PAGE + int'(tok_in.offs[OFW-1:0]));
          tok_next.st    = ST_OK;
        end
      end
      CMD_FREE: begin
        if (!tok_in.found && !valid) begin
          tok_next.found = 1'b1;
          tok_next.idx   = FRAME_W_MAX'(IDX);
          tok_next.st    = ST_OK;
        end
      end
      CMD_VICTIM: begin
        // first never-stamped frame wins; else lowest stamp, ties to lower index
        if (!tok_in.found) begin
          if (!stamped) begin
            tok_next.found = 1'b1;
            tok_next.idx   = FRAME_W_MAX'(IDX);
          end else if ((IDX == 0) || (stamp < tok_in.best_stamp)) begin
            tok_next.idx        = FRAME_W_MAX'(IDX);
            tok_next.best_stamp = stamp;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      stamped <= 1'b0;
      loaded  <= '0;
    end else if (tok_in.vld) begin
      if (hit_me) begin
        stamped <= 1'b1;
        if (tok_in.cmd == CMD_LOAD) begin
          valid                        <= 1'b1;
          loaded[tok_in.offs[OFW-1:0]] <= 1'b1;
        end
      end
      if ((tok_in.cmd == CMD_REMOVE) && own_match) begin
        valid  <= 1'b0;
        loaded <= '0;
      end
    end
  end

  // Payload of the frame; only read while valid or stamped
  always_ff @(posedge clk) begin
    if (hit_me) begin
      stamp <= tok_in.stamp;
      if (tok_in.cmd == CMD_LOAD) begin
        tag  <= tok_in.owner[OWNER_BITS-1:0];
        page <= tok_in.page;
      end
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ hw/rtl/page_frame_table_lru.sv @@
// Page frame table with timestamp LRU replacement: a chain of frame cells.
// A word is captured, launched into the cell chain and its result registered at
// the output. A new word is accepted only in the idle state, once the last result
// has been loaded into the output register; every command walks the whole cell
// chain, one frame per cycle. Reset: synchronous; clears frame valid flags,
// loaded slots, stamp marks and the stamp counter.
module page_frame_table_lru import pft_pkg::*; #(
  parameter int NUM_FRAMES     = 16,
  parameter int SLOTS_PER_PAGE = 4,
  parameter int OWNER_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  frame_index,
  input  logic [7:0]  owner_id,
  input  logic [9:0]  page_number,
  input  logic [7:0]  line_offset,
  input  logic [11:0] line_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  frame_out,
  output logic [5:0]  slot_index
);

  localparam int FW     = $clog2(NUM_FRAMES);
  localparam int DIV_S  = 17;
  localparam int DIV_M  = (2 ** DIV_S + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
  localparam int PROD_W = LINE_W + DIV_S + 1;

  state_t state, state_next;
  logic [STAMP_W-1:0] stamp_counter;

  // Captured word
  logic [2:0]        cmd_q;
  logic [7:0]        frame_q;
  logic [7:0]        owner_q;
  logic [PAGE_W-1:0] page_q;
  logic [7:0]        offset_q;
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] lp_q;

  logic [PROD_W-1:0]       prod;
  logic [LINE_W-1:0]       lo_full;
  logic [OWNER_BITS+7:0]   owner_ext;
  logic                    frame_ok;
  logic                    off_ok;
  pft_tok_t                head;
  pft_tok_t                chain [0:NUM_FRAMES];
  pft_tok_t                tail;
  logic [NUM_FRAMES-1:0]   tok_vld;

  logic                    out_free;
  logic                    out_load;
  logic                    out_from_pend;
  logic                    pend_load;
  status_t                 pend_st;
  logic [FOUT_W-1:0]       pend_frame;
  logic [SLOT_W-1:0]       pend_slot;
  logic [FOUT_W-1:0]       tail_frame;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Line to page by reciprocal multiply
  assign prod = PROD_W'(line_number) * PROD_W'(DIV_M);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q    <= cmd;
      frame_q  <= frame_index;
      owner_q  <= owner_id;
      page_q   <= page_number;
      offset_q <= line_offset;
      line_q   <= line_number;
      lp_q     <= prod[DIV_S +: LINE_W];
    end
  end

  // Build the token that enters the first cell
  assign lo_full   = line_q - LINE_W'(lp_q * LINE_W'(SLOTS_PER_PAGE));
  assign owner_ext = {{OWNER_BITS{1'b0}}, owner_q};
  assign frame_ok  = ({1'b0, frame_q} < 9'(NUM_FRAMES));
  assign off_ok    = ({1'b0, offset_q} < 9'(SLOTS_PER_PAGE));

  always_comb begin
    head       = '0;
    head.vld   = (state == S_LAUNCH);
    head.cmd   = cmd_q;
    head.frame = frame_q;
    head.owner = OWNER_W_MAX'(owner_ext[OWNER_BITS-1:0]);
    head.page  = page_q;
    head.lpage = lp_q;
    head.stamp = stamp_counter;
    head.st    = ST_MISS;
    case (cmd_q)
      CMD_LOAD: begin
        head.offs = offset_q[OFF_W_MAX-1:0];
        if (!frame_ok) begin
          head.st = ST_BAD_FRAME;
        end else if (!off_ok) begin
          head.st = ST_BAD_OFFSET;
        end else begin
          head.st = ST_OK;
          head.wr = 1'b1;
        end
      end
      CMD_TOUCH: begin
        if (!frame_ok) begin
          head.st = ST_BAD_FRAME;
        end else begin
          head.st = ST_OK;
          head.wr = 1'b1;
        end
      end
      CMD_LOOKUP: head.offs = lo_full[OFF_W_MAX-1:0];
      CMD_REMOVE: head.st = ST_OK;
      CMD_VICTIM: head.st = ST_OK;
      default:    head.st = ST_MISS;
    endcase
  end

  // Stamp counter advances once per load or touch that succeeds
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
    end else if ((state == S_LAUNCH) && head.wr) begin
      stamp_counter <= stamp_counter + 1'b1;
    end
  end

  // Chain of frame cells
  assign chain[0] = head;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    pft_cell #(
      .IDX            (i),
      .NUM_FRAMES     (NUM_FRAMES),
      .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
      .OWNER_BITS     (OWNER_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
    assign tok_vld[i] = chain[i+1].vld;
  end

  assign tail       = chain[NUM_FRAMES];
  assign tail_frame = FOUT_W'(tail.idx[FW-1:0]);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    out_from_pend = 1'b0;
    pend_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: state_next = S_SCAN;
      S_SCAN: begin
        if (tail.vld) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            pend_load  = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_from_pend = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result held while the output is busy
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_st    <= tail.st;
      pend_frame <= tail_frame;
      pend_slot  <= tail.slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (out_from_pend) begin
        status     <= pend_st;
        frame_out  <= pend_frame;
        slot_index <= pend_slot;
      end else begin
        status     <= tail.st;
        frame_out  <= tail_frame;
        slot_index <= tail.slot;
      end
    end
  end

`ifndef ASSERT_OFF
  // Never more than one command in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  // A token leaves the chain only while the sequencer waits for it
  a_tail_scan: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> (state == S_SCAN))
    else $error("token left the chain outside the scan state");

  // An accepted word launches in the next cycle
  a_launch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LAUNCH))
    else $error("accepted word not launched");

  // The counter moves only when a token is launched
  a_stamp_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_LAUNCH) |=> $stable(stamp_counter))
    else $error("stamp counter changed outside launch");
`endif

endmodule
